/* design/utfsan_pkg.sv */
// ----------------------------------------------------------------------------
// utfsan_pkg
// Shared types and constants for the UTF-8 sanitizer with newline
// normalization: request and result payloads, the decoded result list.
// ----------------------------------------------------------------------------
package utfsan_pkg;

	// Byte values used by the decoder
	localparam logic [7:0] REP_B0   = 8'hEF;
	localparam logic [7:0] REP_B1   = 8'hBF;
	localparam logic [7:0] REP_B2   = 8'hBD;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [7:0] LEAD_E0  = 8'hE0;
	localparam logic [7:0] LEAD_ED  = 8'hED;
	localparam logic [7:0] LEAD_F0  = 8'hF0;
	localparam logic [7:0] LEAD_F4  = 8'hF4;
	localparam logic [7:0] CONT_LO  = 8'h80;
	localparam logic [7:0] CONT_HI  = 8'hBF;
	localparam logic [7:0] CONT_E0_LO = 8'hA0;
	localparam logic [7:0] CONT_ED_HI = 8'h9F;
	localparam logic [7:0] CONT_F0_LO = 8'h90;
	localparam logic [7:0] CONT_F4_HI = 8'h8F;
	localparam logic [7:0] CHR_NUL  = 8'h00;
	localparam logic [7:0] CHR_LF   = 8'h0A;
	localparam logic [7:0] CHR_FF   = 8'h0C;
	localparam logic [7:0] CHR_CR   = 8'h0D;

	// Most result bytes one request can cause
	localparam int MAX_OUT = 6;

	// Request payload
	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} item_t;

	// Result payload
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       run_last;
		logic       output_end;
	} result_t;

	// All results of one request, first byte in the low bits
	typedef struct packed {
		logic [8*MAX_OUT-1:0] data;
		logic [2:0]           cnt;
		logic                 present;
		logic                 is_end;
	} res_list_t;

endpackage

/* design/utfsan_decode.sv */
// ----------------------------------------------------------------------------
// utfsan_decode
// Decoder state (held sequence, CR flag) and the single-pass logic that
// turns one request byte into its list of result bytes.
// ----------------------------------------------------------------------------
module utfsan_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utfsan_pkg::item_t     item,
	input  logic                  advance,
	output utfsan_pkg::res_list_t res
);
	import utfsan_pkg::*;

	typedef struct packed {
		logic [1:0]  n;
		logic [23:0] bytes;
		logic        cr;
		logic        hold;
		logic [1:0]  need;
	} fresh_t;

	logic [7:0] held0_q, held1_q, held2_q;
	logic [1:0] held_cnt_q, need_q;
	logic       cr_q;

	logic [1:0] held_cnt_d, need_d;
	logic       cr_d;
	logic       wr0, wr1, wr2;
	logic [7:0] lo, hi;
	logic       cont_ok;
	logic       run_fresh;
	fresh_t     f;
	res_list_t  lst;

	// Append one byte to the result list
	function automatic res_list_t put(res_list_t l, logic [7:0] b);
		res_list_t r;
		r = l;
		if (l.cnt < 3'(MAX_OUT)) begin
			r.data = l.data | ((8*MAX_OUT)'(b) << {l.cnt, 3'b000});
			r.cnt  = l.cnt + 3'd1;
		end
		return r;
	endfunction

	function automatic res_list_t put_rep(res_list_t l);
		res_list_t r;
		r = put(l, REP_B0);
		r = put(r, REP_B1);
		r = put(r, REP_B2);
		return r;
	endfunction

	// Handle a byte with nothing held
	function automatic fresh_t fresh(logic [7:0] b, logic was_cr);
		fresh_t r;
		r = '0;
		if (b < CONT_LO) begin
			if (b == CHR_CR) begin
				r.n = 2'd1;
				r.bytes = {16'h0, CHR_LF};
				r.cr = 1'b1;
			end else if (b == CHR_LF && was_cr) begin
				r.n = 2'd0;
			end else if (b == CHR_FF) begin
				r.n = 2'd1;
				r.bytes = {16'h0, CHR_LF};
			end else if (b == CHR_NUL) begin
				r.n = 2'd3;
				r.bytes = {REP_B2, REP_B1, REP_B0};
			end else begin
				r.n = 2'd1;
				r.bytes = {16'h0, b};
			end
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			r.hold = 1'b1;
			r.need = 2'd1;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			r.hold = 1'b1;
			r.need = 2'd2;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			r.hold = 1'b1;
			r.need = 2'd3;
		end else begin
			r.n = 2'd3;
			r.bytes = {REP_B2, REP_B1, REP_B0};
		end
		return r;
	endfunction

	// Tight second-byte range after the lead
	always_comb begin
		lo = CONT_LO;
		hi = CONT_HI;
		if (held_cnt_q == 2'd1) begin
			if (held0_q == LEAD_E0) lo = CONT_E0_LO;
			if (held0_q == LEAD_ED) hi = CONT_ED_HI;
			if (held0_q == LEAD_F0) lo = CONT_F0_LO;
			if (held0_q == LEAD_F4) hi = CONT_F4_HI;
		end
		cont_ok = (item.in_byte >= lo) && (item.in_byte <= hi);
	end

	assign f = fresh(item.in_byte, cr_q);

	// Build the result list and the next state
	always_comb begin
		lst        = '0;
		held_cnt_d = held_cnt_q;
		need_d     = need_q;
		cr_d       = cr_q;
		wr0        = 1'b0;
		wr1        = 1'b0;
		wr2        = 1'b0;
		run_fresh  = 1'b0;

		if (held_cnt_q == 2'd0) begin
			run_fresh = 1'b1;
		end else if (cont_ok) begin
			if (held_cnt_q >= need_q) begin
				// sequence complete: pass it through
				lst = put(lst, held0_q);
				if (held_cnt_q >= 2'd2) lst = put(lst, held1_q);
				if (held_cnt_q == 2'd3) lst = put(lst, held2_q);
				lst = put(lst, item.in_byte);
				held_cnt_d = 2'd0;
				need_d     = 2'd0;
			end else begin
				wr1 = (held_cnt_q == 2'd1);
				wr2 = (held_cnt_q == 2'd2);
				held_cnt_d = held_cnt_q + 2'd1;
			end
		end else begin
			// broken sequence: replace it, then redo this byte
			lst = put_rep(lst);
			held_cnt_d = 2'd0;
			need_d     = 2'd0;
			run_fresh  = 1'b1;
		end

		if (run_fresh) begin
			for (int k = 0; k < 3; k++) begin
				if (k < int'(f.n)) lst = put(lst, f.bytes[8*k +: 8]);
			end
			cr_d = f.cr;
			if (f.hold) begin
				wr0        = 1'b1;
				held_cnt_d = 2'd1;
				need_d     = f.need;
			end
		end

		lst.present = 1'b1;
		lst.is_end  = item.stream_end;
		if (item.stream_end) begin
			// truncated tail gives one replacement
			if (held_cnt_d != 2'd0) lst = put_rep(lst);
			held_cnt_d = 2'd0;
			need_d     = 2'd0;
			cr_d       = 1'b0;
			if (lst.cnt == 3'd0) begin
				lst.cnt     = 3'd1;
				lst.present = 1'b0;
			end
		end
	end

	assign res = lst;

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			need_q     <= 2'd0;
			cr_q       <= 1'b0;
		end else if (advance) begin
			held_cnt_q <= held_cnt_d;
			need_q     <= need_d;
			cr_q       <= cr_d;
		end
	end

	// Hold bytes of an unfinished sequence
	always_ff @(posedge clk) begin
		if (advance && wr0) held0_q <= item.in_byte;
		if (advance && wr1) held1_q <= item.in_byte;
		if (advance && wr2) held2_q <= item.in_byte;
	end

endmodule

/* design/utfsan_outbuf.sv */
// ----------------------------------------------------------------------------
// utfsan_outbuf
// Result register: holds one request's byte list and sends it one byte per
// cycle while rsp_stall is low, marking the last byte of run and stream.
// ----------------------------------------------------------------------------
module utfsan_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  utfsan_pkg::res_list_t load_list,
	input  logic                  load,
	output logic                  ready,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output utfsan_pkg::result_t   rsp
);
	import utfsan_pkg::*;

	logic [8*MAX_OUT-1:0] data_q;
	logic [2:0]           cnt_q;
	logic                 present_q;
	logic                 end_q;
	logic                 take;
	logic                 last;

	assign rsp_valid = (cnt_q != 3'd0);
	assign take      = rsp_valid && !rsp_stall;
	assign last      = (cnt_q == 3'd1);
	assign ready     = !rsp_valid || (last && !rsp_stall);

	always_comb begin
		rsp.out_byte     = data_q[7:0];
		rsp.byte_present = present_q;
		rsp.run_last     = last;
		rsp.output_end   = last && end_q;
	end

	// Load a new list, or shift out the byte just taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (load && ready) begin
			cnt_q <= load_list.cnt;
		end else if (take) begin
			cnt_q <= cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && ready) begin
			data_q    <= load_list.data;
			present_q <= load_list.present;
			end_q     <= load_list.is_end;
		end else if (take) begin
			data_q <= data_q >> 8;
		end
	end

endmodule

/* design/utf8_sanitize_newline_normalize.sv */
// ----------------------------------------------------------------------------
// utf8_sanitize_newline_normalize
// UTF-8 sanitizer: CR, CRLF and FF become LF, NUL and ill-formed sequences
// become U+FFFD, well-formed UTF-8 passes unchanged.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  --------+-----------------------------+------------------------------------
//  request | req_valid, req_stall, req   | in_byte, stream_end
//  result  | rsp_valid, rsp_stall, rsp   | out_byte, byte_present, run_last,
//          |                             | output_end
//
//  A request is registered, decoded in one pass into 0 to 6 result bytes, and
//  those are sent one per cycle while rsp_stall is low from the result
//  register. A request passes the input register and then the result register
//  before its first result shows. Reset clears the decoder state and empties
//  both registers. req_stall rises while the input register holds a request
//  and the result register still holds bytes that will not drain this cycle;
//  requests that give no result wait for the result register too.
// ----------------------------------------------------------------------------
module utf8_sanitize_newline_normalize (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  utfsan_pkg::item_t   req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output utfsan_pkg::result_t rsp
);
	import utfsan_pkg::*;

	item_t     item_s1;
	logic      valid_s1;
	logic      ob_ready;
	logic      advance;
	res_list_t list;

	assign advance   = valid_s1 && ob_ready;
	assign req_stall = valid_s1 && !ob_ready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) item_s1 <= req;
	end

	utfsan_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.advance (advance),
		.res     (list)
	);

	utfsan_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load_list (list),
		.load      (valid_s1),
		.ready     (ob_ready),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

/* bench/utf8_sanitize_newline_normalize_tb.sv */
// ----------------------------------------------------------------------------
// utf8_sanitize_newline_normalize_tb
// Self-checking bench for the UTF-8 sanitizer. Requests go in one at a time
// over the valid/stall channel while a local decoder works out the sanitized
// bytes each request should cause. Every result leaving the block is checked
// against the oldest of those bytes. Directed cases cover newline folding,
// tight second-byte ranges, broken sequences and stream ends. Random traffic
// mixes well-formed sequences with broken ones and noise, with random gaps
// on both channels while idling is on.
// ----------------------------------------------------------------------------
module utf8_sanitize_newline_normalize_tb;
	import utfsan_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int MAX_REPORTS = 10;

	// Kinds of random request runs
	typedef enum int {
		RUN_ASCII,
		RUN_SEQ2,
		RUN_SEQ3,
		RUN_SEQ4,
		RUN_BROKEN,
		RUN_NOISE,
		RUN_CRLF
	} run_kind_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_stall;
	item_t   req = '0;
	logic    rsp_valid;
	logic    rsp_stall = 1'b0;
	result_t rsp;

	// Decoder state of the local predictor
	logic [7:0]  seq_buf [3];
	int unsigned seq_len = 0;
	int unsigned seq_need = 0;
	bit          prev_cr = 1'b0;
	logic [7:0]  emit_buf [MAX_OUT];
	int          emit_cnt;

	// Sanitized bytes still owed by the block
	result_t sanitized_q [$];

	bit idle_on = 1'b1;
	int fail_cnt = 0;
	int requests_sent = 0;
	int directed_sent = 0;
	int results_seen = 0;
	int streams_closed = 0;
	int cycle_cnt = 0;
	int stall_left = 0;

	utf8_sanitize_newline_normalize DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #6 clk = ~clk;

	// Pick an idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void emit(logic [7:0] v);
		if (emit_cnt < MAX_OUT) begin
			emit_buf[emit_cnt] = v;
			emit_cnt++;
		end
	endfunction

	function automatic void emit_replacement();
		emit(REP_B0);
		emit(REP_B1);
		emit(REP_B2);
	endfunction

	// Decode a byte with no sequence in progress
	function automatic void start_byte(logic [7:0] v);
		bit was_cr;
		was_cr = prev_cr;
		prev_cr = 1'b0;
		if (v < CONT_LO) begin
			if (v == CHR_CR) begin
				emit(CHR_LF);
				prev_cr = 1'b1;
			end else if (v == CHR_LF && was_cr) begin
				// second half of CRLF, nothing to emit
			end else if (v == CHR_FF) begin
				emit(CHR_LF);
			end else if (v == CHR_NUL) begin
				emit_replacement();
			end else begin
				emit(v);
			end
			return;
		end
		if (v >= LEAD2_LO && v <= LEAD2_HI)
			seq_need = 1;
		else if (v >= LEAD3_LO && v <= LEAD3_HI)
			seq_need = 2;
		else if (v >= LEAD4_LO && v <= LEAD4_HI)
			seq_need = 3;
		else begin
			emit_replacement();
			return;
		end
		seq_buf[0] = v;
		seq_len = 1;
	endfunction

	// Second bytes use the tight ranges, later ones the plain range
	function automatic bit continuation_fits(logic [7:0] v);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (seq_len == 1) begin
			if (seq_buf[0] == LEAD_E0) lo = CONT_E0_LO;
			if (seq_buf[0] == LEAD_ED) hi = CONT_ED_HI;
			if (seq_buf[0] == LEAD_F0) lo = CONT_F0_LO;
			if (seq_buf[0] == LEAD_F4) hi = CONT_F4_HI;
		end
		return v >= lo && v <= hi;
	endfunction

	function automatic void decode_byte(logic [7:0] v);
		if (seq_len == 0) begin
			start_byte(v);
			return;
		end
		if (continuation_fits(v)) begin
			if (seq_len >= seq_need) begin
				for (int k = 0; k < seq_len && k < 3; k++)
					emit(seq_buf[k]);
				emit(v);
				seq_len = 0;
				seq_need = 0;
			end else if (seq_len < 3) begin
				seq_buf[seq_len] = v;
				seq_len++;
			end else begin
				emit_replacement();
				seq_len = 0;
				seq_need = 0;
			end
			return;
		end
		// Broken sequence: replace what is held, then decode the byte afresh
		emit_replacement();
		seq_len = 0;
		seq_need = 0;
		start_byte(v);
	endfunction

	// Work out the results of one accepted request and queue them
	function automatic void sanitize_request(logic [7:0] v, logic closes);
		result_t r;
		emit_cnt = 0;
		decode_byte(v);
		if (closes) begin
			if (seq_len != 0)
				emit_replacement();
			seq_len = 0;
			seq_need = 0;
			prev_cr = 1'b0;
			streams_closed++;
			if (emit_cnt == 0) begin
				r.out_byte = 8'h00;
				r.byte_present = 1'b0;
				r.run_last = 1'b1;
				r.output_end = 1'b1;
				sanitized_q.push_back(r);
				return;
			end
		end
		for (int k = 0; k < emit_cnt; k++) begin
			r.out_byte = emit_buf[k];
			r.byte_present = 1'b1;
			r.run_last = (k == emit_cnt - 1);
			r.output_end = (k == emit_cnt - 1) && closes;
			sanitized_q.push_back(r);
		end
	endfunction

	// Send one request; called and returns at a rising edge
	task automatic send_item(input logic [7:0] value, input logic closes);
		int gap;
		req <= '{in_byte: value, stream_end: closes};
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		sanitize_request(value, closes);
		requests_sent++;
		gap = idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Check results and drive random result stalls
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (sanitized_q.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= MAX_REPORTS)
					$display("ERROR: unexpected result: byte %02h present %b last %b end %b",
						rsp.out_byte, rsp.byte_present, rsp.run_last, rsp.output_end);
			end else begin
				want = sanitized_q.pop_front();
				if (rsp.out_byte !== want.out_byte || rsp.byte_present !== want.byte_present ||
					rsp.run_last !== want.run_last || rsp.output_end !== want.output_end) begin
					fail_cnt++;
					if (fail_cnt <= MAX_REPORTS) begin
						$display("ERROR: result %0d: expected byte %02h present %b last %b end %b",
							results_seen, want.out_byte, want.byte_present, want.run_last,
							want.output_end);
						$display("       got byte %02h present %b last %b end %b",
							rsp.out_byte, rsp.byte_present, rsp.run_last, rsp.output_end);
					end
				end
			end
		end
		if (!idle_on) begin
			rsp_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			rsp_stall <= 1'b1;
			stall_left--;
		end else begin
			rsp_stall <= 1'b0;
			stall_left = pick_gap();
		end
	end

	// Newline folding, NUL and the ASCII extremes
	task automatic test_newline_rules();
		send_item(CHR_CR, 1'b0);
		send_item(CHR_LF, 1'b0);
		send_item(CHR_FF, 1'b0);
		send_item(CHR_LF, 1'b0);
		send_item(CHR_NUL, 1'b0);
		send_item(8'h7F, 1'b0);
	endtask

	// Well-formed sequences at the edges of their ranges
	task automatic test_well_formed();
		send_item(LEAD2_LO, 1'b0);
		send_item(CONT_LO, 1'b0);
		send_item(LEAD_F4, 1'b0);
		send_item(CONT_F4_HI, 1'b0);
		send_item(CONT_HI, 1'b0);
		send_item(CONT_HI, 1'b0);
	endtask

	// Invalid lead, second byte outside the tight range, broken 4-byte run
	task automatic test_ill_formed();
		send_item(8'hFF, 1'b0);
		send_item(LEAD_E0, 1'b0);
		send_item(CONT_ED_HI, 1'b0);
		send_item(LEAD_F0, 1'b0);
		send_item(CONT_F0_LO, 1'b0);
		send_item(8'h41, 1'b0);
	endtask

	// Truncated tail, empty end marker, CRLF split across two streams
	task automatic test_stream_end();
		send_item(8'hE2, 1'b0);
		send_item(8'h82, 1'b1);
		send_item(CHR_CR, 1'b0);
		send_item(CHR_LF, 1'b1);
		send_item(CHR_CR, 1'b1);
		send_item(CHR_LF, 1'b0);
	endtask

	// Legal second byte for a lead, honoring the tight ranges
	function automatic logic [7:0] pick_second(logic [7:0] lead);
		case (lead)
			LEAD_E0: return 8'($urandom_range(CONT_E0_LO, CONT_HI));
			LEAD_ED: return 8'($urandom_range(CONT_LO, CONT_ED_HI));
			LEAD_F0: return 8'($urandom_range(CONT_F0_LO, CONT_HI));
			LEAD_F4: return 8'($urandom_range(CONT_LO, CONT_F4_HI));
			default: return 8'($urandom_range(CONT_LO, CONT_HI));
		endcase
	endfunction

	// Random runs: mostly well-formed sequences, some broken ones and noise
	task automatic test_random_traffic(input int count, input bit idling);
		logic [7:0] run_q [$];
		run_kind_t  kind;
		int         r;
		int         len;
		idle_on = idling;
		while (count > 0) begin
			run_q.delete();
			r = $urandom_range(0, 99);
			if (r < 25)
				kind = RUN_ASCII;
			else if (r < 37)
				kind = RUN_SEQ2;
			else if (r < 52)
				kind = RUN_SEQ3;
			else if (r < 67)
				kind = RUN_SEQ4;
			else if (r < 82)
				kind = RUN_BROKEN;
			else if (r < 92)
				kind = RUN_NOISE;
			else
				kind = RUN_CRLF;
			case (kind)
				RUN_ASCII: run_q.push_back(8'($urandom_range(0, 8'h7F)));
				RUN_NOISE: run_q.push_back(8'($urandom_range(0, 8'hFF)));
				RUN_CRLF: begin
					run_q.push_back(CHR_CR);
					run_q.push_back(CHR_LF);
				end
				default: begin
					len = kind == RUN_SEQ2 ? 2 : kind == RUN_SEQ3 ? 3 :
						kind == RUN_SEQ4 ? 4 : $urandom_range(2, 4);
					run_q.push_back(len == 2 ? 8'($urandom_range(LEAD2_LO, LEAD2_HI)) :
						len == 3 ? 8'($urandom_range(LEAD3_LO, LEAD3_HI)) :
						8'($urandom_range(LEAD4_LO, LEAD4_HI)));
					run_q.push_back(pick_second(run_q[0]));
					while (run_q.size() < len)
						run_q.push_back(8'($urandom_range(CONT_LO, CONT_HI)));
					// Cut the sequence short and follow it with any byte
					if (kind == RUN_BROKEN) begin
						len = $urandom_range(1, len - 1);
						while (run_q.size() > len)
							void'(run_q.pop_back());
						run_q.push_back(8'($urandom_range(0, 8'hFF)));
					end
				end
			endcase
			foreach (run_q[i]) begin
				send_item(run_q[i], $urandom_range(0, 99) < 4);
				count--;
			end
		end
	endtask

	// Stop a run that hangs
	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles, %0d results still expected", cycle_cnt,
			sanitized_q.size());
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_newline_rules();
		test_well_formed();
		test_ill_formed();
		test_stream_end();
		directed_sent = requests_sent;
		test_random_traffic(120, 1'b1);
		test_random_traffic(66, 1'b0);
		req_valid <= 1'b0;
		while (sanitized_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d requests (%0d directed) over %0d closed streams",
			requests_sent, directed_sent, streams_closed);
		$display("Checked %0d result bytes, %0d failures", results_seen, fail_cnt);
		if (fail_cnt == 0 && sanitized_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* sim.f */
design/utfsan_pkg.sv
design/utfsan_decode.sv
design/utfsan_outbuf.sv
design/utf8_sanitize_newline_normalize.sv
bench/utf8_sanitize_newline_normalize_tb.sv
